// File: hdl/gcm_pkg.sv
// Shared types, register map and saturation helper of the gain, compressor and mixer core.
`default_nettype none

package gcm_pkg;

   localparam int DEF_SAMPLE_WIDTH = 32;
   localparam int NUM_STAGES       = 8;
   localparam int CSR_INDEX_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH   = 40;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INPUT_GAIN     = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COMP_RATIO     = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COMP_THRESHOLD = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIX_MODE       = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SURROUND_GAIN0 = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SURROUND_GAIN1 = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LFE_GAIN0      = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LFE_GAIN1      = 4'd7;

   localparam logic signed [31:0] RST_INPUT_GAIN     = 32'sd1073741824;
   localparam logic signed [31:0] RST_COMP_RATIO     = 32'sd107374182;
   localparam logic signed [31:0] RST_COMP_THRESHOLD = 32'sd644245094;
   localparam logic               RST_MIX_MODE       = 1'b0;
   localparam logic signed [39:0] RST_SURROUND_GAIN0 = 40'sd343597384;
   localparam logic signed [39:0] RST_SURROUND_GAIN1 = 40'sd1073741824;
   localparam logic signed [39:0] RST_LFE_GAIN0      = 40'sd3822520893;
   localparam logic signed [39:0] RST_LFE_GAIN1      = 40'sd3027951780;

   localparam logic signed [31:0] Q31_MAX  = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q31_MIN  = 32'sh80000000;
   localparam logic signed [72:0] WIDE_MAX = 73'sd2147483647;
   localparam logic signed [72:0] WIDE_MIN = -73'sd2147483648;

   typedef struct packed {
      logic signed [31:0] in_left;
      logic signed [31:0] in_right;
      logic signed [31:0] in_center;
      logic signed [31:0] in_aux_six;
      logic signed [31:0] in_aux_seven;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_mix_left;
      logic signed [31:0] out_gained_right;
      logic signed [31:0] out_center;
      logic signed [31:0] out_left_surround;
      logic signed [31:0] out_right_surround;
      logic signed [31:0] out_lfe;
      logic signed [31:0] out_aux_six;
      logic signed [31:0] out_aux_seven;
   } rsp_type;

   function automatic logic signed [31:0] sat_q31(input logic signed [72:0] x);
      logic signed [31:0] r;
      if (x > WIDE_MAX) begin
         r = Q31_MAX;
      end else if (x < WIDE_MIN) begin
         r = Q31_MIN;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/gcm_mul.sv
// Registered signed multiplier with load enable.
`default_nettype none

module gcm_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic signed [A_WIDTH-1:0]         a,
   input  wire logic signed [B_WIDTH-1:0]         b,
   output      logic signed [A_WIDTH+B_WIDTH-1:0] p
);

   logic signed [A_WIDTH+B_WIDTH-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= a * b;
      end
   end

   assign p = prod_ff;

endmodule

`default_nettype wire

// File: hdl/gain_compressor_channel_mixer_core.sv
// Top level of the eight-channel gain, hard-knee compressor and channel mixer.
//
// One audio frame enters per clock while req_ready is high and leaves as an eight-channel frame; the
// pipeline is eight register stages, cut at the multipliers (input gain, left-surround gain
// halves, compressor slope, LFE gain halves) with the saturating adds in the stages between.
// Frames advance independently, so bubbles close up while the output is stalled and req_ready
// drops only when all eight stages hold frames and rsp_ready is low. The register port is
// always ready; write it only while no frame is in flight. Samples are taken from and
// returned in the low SAMPLE_WIDTH bits of each field.
`default_nettype none

module gain_compressor_channel_mixer_core #(
   parameter int SAMPLE_WIDTH = gcm_pkg::DEF_SAMPLE_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire gcm_pkg::req_type                     req_payload,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      gcm_pkg::rsp_type                     rsp_payload,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [gcm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [gcm_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int          NS        = gcm_pkg::NUM_STAGES;
   localparam int          SMP_SHIFT = 32 - SAMPLE_WIDTH;
   localparam logic [31:0] SMP_MASK  = 32'((64'd1 << SAMPLE_WIDTH) - 64'd1);

   localparam logic [1:0] KNEE_NONE  = 2'd0;
   localparam logic [1:0] KNEE_ABOVE = 2'd1;
   localparam logic [1:0] KNEE_BELOW = 2'd2;

   typedef struct packed {
      logic signed [31:0] center;
      logic signed [31:0] aux_six;
      logic signed [31:0] aux_seven;
      logic signed [31:0] gl;
      logic signed [31:0] gr;
      logic signed [31:0] rs;
      logic signed [31:0] ls;
      logic signed [31:0] kop;
      logic        [1:0]  kmode;
      logic signed [31:0] c;
      logic signed [31:0] s1;
      logic signed [31:0] lfe;
      logic signed [31:0] mix;
   } side_type;

   logic signed [31:0] gain_ff;
   logic signed [31:0] ratio_ff;
   logic signed [31:0] thr_ff;
   logic               mode_ff;
   logic signed [39:0] sg0_ff;
   logic signed [39:0] sg1_ff;
   logic signed [39:0] lg0_ff;
   logic signed [39:0] lg1_ff;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] adv;
   side_type      side_ff [NS];
   side_type      side_in [NS];

   logic signed [31:0] l_ext;
   logic signed [31:0] r_ext;
   logic signed [39:0] sg;
   logic signed [39:0] lg;
   logic signed [63:0] m_l;
   logic signed [63:0] m_r;
   logic signed [63:0] m_lsl;
   logic signed [40:0] m_lsh;
   logic signed [63:0] m_k;
   logic signed [63:0] m_lfl;
   logic signed [40:0] m_lfh;
   logic signed [32:0] d_above;
   logic signed [32:0] d_below;
   logic               bypass;
   logic signed [72:0] ls_wide;
   logic signed [72:0] lfe_wide;
   logic signed [31:0] kq;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= gcm_pkg::RST_INPUT_GAIN;
         ratio_ff <= gcm_pkg::RST_COMP_RATIO;
         thr_ff   <= gcm_pkg::RST_COMP_THRESHOLD;
         mode_ff  <= gcm_pkg::RST_MIX_MODE;
         sg0_ff   <= gcm_pkg::RST_SURROUND_GAIN0;
         sg1_ff   <= gcm_pkg::RST_SURROUND_GAIN1;
         lg0_ff   <= gcm_pkg::RST_LFE_GAIN0;
         lg1_ff   <= gcm_pkg::RST_LFE_GAIN1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gcm_pkg::REG_INPUT_GAIN:     gain_ff  <= csr_data[31:0];
            gcm_pkg::REG_COMP_RATIO:     ratio_ff <= csr_data[31:0];
            gcm_pkg::REG_COMP_THRESHOLD: thr_ff   <= csr_data[31:0];
            gcm_pkg::REG_MIX_MODE:       mode_ff  <= csr_data[0];
            gcm_pkg::REG_SURROUND_GAIN0: sg0_ff   <= csr_data[39:0];
            gcm_pkg::REG_SURROUND_GAIN1: sg1_ff   <= csr_data[39:0];
            gcm_pkg::REG_LFE_GAIN0:      lg0_ff   <= csr_data[39:0];
            gcm_pkg::REG_LFE_GAIN1:      lg1_ff   <= csr_data[39:0];
            default: ;
         endcase
      end
   end

   assign sg = mode_ff ? sg1_ff : sg0_ff;
   assign lg = mode_ff ? lg1_ff : lg0_ff;

   // stage valid chain: a stage advances when empty or when the next one advances
   always_comb begin
      adv[NS-1] = ~v_ff[NS-1] | rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = ~v_ff[k] | adv[k+1];
      end
   end

   assign v_in      = {v_ff[NS-2:0], req_valid};
   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign l_ext = $signed(req_payload.in_left  << SMP_SHIFT) >>> SMP_SHIFT;
   assign r_ext = $signed(req_payload.in_right << SMP_SHIFT) >>> SMP_SHIFT;

   gcm_mul #(.A_WIDTH(32), .B_WIDTH(32)) u_mul_left (
      .clock(clock), .en(adv[0]), .a(l_ext), .b(gain_ff), .p(m_l)
   );
   gcm_mul #(.A_WIDTH(32), .B_WIDTH(32)) u_mul_right (
      .clock(clock), .en(adv[0]), .a(r_ext), .b(gain_ff), .p(m_r)
   );
   gcm_mul #(.A_WIDTH(32), .B_WIDTH(32)) u_mul_ls_lo (
      .clock(clock), .en(adv[2]), .a(side_ff[1].gl), .b($signed({1'b0, sg[30:0]})), .p(m_lsl)
   );
   gcm_mul #(.A_WIDTH(32), .B_WIDTH(9)) u_mul_ls_hi (
      .clock(clock), .en(adv[2]), .a(side_ff[1].gl), .b($signed(sg[39:31])), .p(m_lsh)
   );
   gcm_mul #(.A_WIDTH(32), .B_WIDTH(32)) u_mul_knee (
      .clock(clock), .en(adv[3]), .a(side_ff[2].kop), .b(ratio_ff), .p(m_k)
   );
   gcm_mul #(.A_WIDTH(32), .B_WIDTH(32)) u_mul_lfe_lo (
      .clock(clock), .en(adv[5]), .a(side_ff[4].c), .b($signed({1'b0, lg[30:0]})), .p(m_lfl)
   );
   gcm_mul #(.A_WIDTH(32), .B_WIDTH(9)) u_mul_lfe_hi (
      .clock(clock), .en(adv[5]), .a(side_ff[4].c), .b($signed(lg[39:31])), .p(m_lfh)
   );

   assign d_above  = 33'(thr_ff) - 33'(side_ff[1].gl);
   assign d_below  = 33'(side_ff[1].gl) + 33'(thr_ff);
   assign bypass   = (ratio_ff == gcm_pkg::Q31_MAX);
   assign ls_wide  = (73'(m_lsh) <<< 31) + 73'(m_lsl);
   assign lfe_wide = (73'(m_lfh) <<< 31) + 73'(m_lfl);
   assign kq       = gcm_pkg::sat_q31(73'(m_k >>> 31));

   always_comb begin
      side_in[0]           = '0;
      side_in[0].center    = req_payload.in_center;
      side_in[0].aux_six   = req_payload.in_aux_six;
      side_in[0].aux_seven = req_payload.in_aux_seven;
      for (int k = 1; k < NS; k++) begin
         side_in[k] = side_ff[k-1];
      end

      // scale left and right
      side_in[1].gl = gcm_pkg::sat_q31(73'(m_l >>> 31));
      side_in[1].gr = gcm_pkg::sat_q31(73'(m_r >>> 31));

      // knee decision and negated right
      side_in[2].rs = gcm_pkg::sat_q31(-73'(side_ff[1].gr));
      if (bypass) begin
         side_in[2].kmode = KNEE_NONE;
      end else if (d_above[32]) begin
         side_in[2].kmode = KNEE_ABOVE;
      end else if (d_below[32]) begin
         side_in[2].kmode = KNEE_BELOW;
      end else begin
         side_in[2].kmode = KNEE_NONE;
      end
      if (d_above[32]) begin
         side_in[2].kop = gcm_pkg::sat_q31(73'(side_ff[1].gl) - 73'(thr_ff));
      end else begin
         side_in[2].kop = gcm_pkg::sat_q31(73'(side_ff[1].gl) + 73'(thr_ff));
      end

      side_in[3].ls = gcm_pkg::sat_q31(ls_wide >>> 31);

      // compressed left and partial mix
      case (side_ff[3].kmode)
         KNEE_ABOVE: side_in[4].c = gcm_pkg::sat_q31(73'(thr_ff) + 73'(kq));
         KNEE_BELOW: side_in[4].c = gcm_pkg::sat_q31(73'(kq) - 73'(thr_ff));
         default:    side_in[4].c = side_ff[3].gl;
      endcase
      side_in[4].s1 = gcm_pkg::sat_q31(73'(side_ff[3].ls) + 73'(side_ff[3].gl));

      side_in[6].lfe = gcm_pkg::sat_q31(lfe_wide >>> 31);

      side_in[7].mix = gcm_pkg::sat_q31(73'(side_ff[6].s1) + 73'(side_ff[6].lfe));
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (adv[k]) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign rsp_valid = v_ff[NS-1];

   always_comb begin
      rsp_payload.out_mix_left       = side_ff[NS-1].mix       & SMP_MASK;
      rsp_payload.out_gained_right   = side_ff[NS-1].gr        & SMP_MASK;
      rsp_payload.out_center         = side_ff[NS-1].center    & SMP_MASK;
      rsp_payload.out_left_surround  = side_ff[NS-1].ls        & SMP_MASK;
      rsp_payload.out_right_surround = side_ff[NS-1].rs        & SMP_MASK;
      rsp_payload.out_lfe            = side_ff[NS-1].lfe       & SMP_MASK;
      rsp_payload.out_aux_six        = side_ff[NS-1].aux_six   & SMP_MASK;
      rsp_payload.out_aux_seven      = side_ff[NS-1].aux_seven & SMP_MASK;
   end

endmodule

`default_nettype wire

// File: hdl/gcm_checker.sv
// Port-level assertions of the mixer core and their bind to the top level.
`default_nettype none

module gcm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire gcm_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(gcm_pkg::NUM_STAGES + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (req_valid && req_ready) begin
         count_in = count_in + CNT_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         count_in = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled item changed or vanished");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("item delivered with none in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(gcm_pkg::NUM_STAGES))
      else $error("more items in flight than stages");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input held off with output stage empty");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("item shown right after reset");

endmodule

bind gain_compressor_channel_mixer_core gcm_checker u_gcm_checker (.*);

`default_nettype wire

// File: tb/gain_compressor_channel_mixer_core_test.sv
// Self-checking testbench of the gain, compressor and channel mixer core with scoreboard.
`timescale 1ns / 100ps

module gain_compressor_channel_mixer_core_test;

   localparam int LEAD_FRAMES     = 100;
   localparam int PHASE_FRAMES    = 150;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int HOLD_OFF_AT     = 250;
   localparam int DRAIN_LIMIT     = 4000;
   localparam int PRINT_LIMIT     = 40;
   localparam int INDEX_W         = gcm_pkg::CSR_INDEX_WIDTH;
   localparam int DATA_W          = gcm_pkg::CSR_DATA_WIDTH;

   localparam logic signed [39:0] GAIN_MAX = 40'sh7FFFFFFFFF;
   localparam logic signed [39:0] GAIN_MIN = 40'sh8000000000;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [DATA_W-1:0]  data;
   } reg_write_type;

   class mix_scoreboard;
      logic signed [31:0] input_gain;
      logic signed [31:0] comp_ratio;
      logic signed [31:0] comp_threshold;
      logic               mix_mode;
      logic signed [39:0] surround_gain [2];
      logic signed [39:0] lfe_gain [2];
      gcm_pkg::rsp_type   pending_frames [$];
      string              field_names [8];
      int                 failures;
      int                 checked;

      function new();
         input_gain       = gcm_pkg::RST_INPUT_GAIN;
         comp_ratio       = gcm_pkg::RST_COMP_RATIO;
         comp_threshold   = gcm_pkg::RST_COMP_THRESHOLD;
         mix_mode         = gcm_pkg::RST_MIX_MODE;
         surround_gain[0] = gcm_pkg::RST_SURROUND_GAIN0;
         surround_gain[1] = gcm_pkg::RST_SURROUND_GAIN1;
         lfe_gain[0]      = gcm_pkg::RST_LFE_GAIN0;
         lfe_gain[1]      = gcm_pkg::RST_LFE_GAIN1;
         field_names = '{"out_mix_left", "out_gained_right", "out_center",
                         "out_left_surround", "out_right_surround", "out_lfe",
                         "out_aux_six", "out_aux_seven"};
         failures = 0;
         checked  = 0;
      endfunction

      task log_fault(input string what);
         failures++;
         if (failures <= PRINT_LIMIT) begin
            $display("[%0t] %s", $time, what);
         end
      endtask

      function void set_register(input logic [INDEX_W-1:0] index,
                                 input logic [DATA_W-1:0] data);
         case (index)
            gcm_pkg::REG_INPUT_GAIN:     input_gain       = data[31:0];
            gcm_pkg::REG_COMP_RATIO:     comp_ratio       = data[31:0];
            gcm_pkg::REG_COMP_THRESHOLD: comp_threshold   = data[31:0];
            gcm_pkg::REG_MIX_MODE:       mix_mode         = data[0];
            gcm_pkg::REG_SURROUND_GAIN0: surround_gain[0] = data;
            gcm_pkg::REG_SURROUND_GAIN1: surround_gain[1] = data;
            gcm_pkg::REG_LFE_GAIN0:      lfe_gain[0]      = data;
            gcm_pkg::REG_LFE_GAIN1:      lfe_gain[1]      = data;
            default: ;
         endcase
      endfunction

      function logic signed [79:0] clamp_q31(input logic signed [79:0] x);
         if (x > 80'(gcm_pkg::Q31_MAX)) begin
            return 80'(gcm_pkg::Q31_MAX);
         end else if (x < 80'(gcm_pkg::Q31_MIN)) begin
            return 80'(gcm_pkg::Q31_MIN);
         end
         return x;
      endfunction

      // floor of the exact product over 2^31, then clamp; serves Q1.31 and Q9.31 gains
      function logic signed [79:0] frac_mul(input logic signed [79:0] a,
                                            input logic signed [79:0] b);
         logic signed [79:0] p;
         p = a * b;
         return clamp_q31(p >>> 31);
      endfunction

      function gcm_pkg::rsp_type predict_frame(input gcm_pkg::req_type f);
         logic signed [79:0] gl, gr, thr, c, ls, lfe, mix, rs;
         gcm_pkg::rsp_type e;
         gl  = frac_mul(80'(f.in_left), 80'(input_gain));
         gr  = frac_mul(80'(f.in_right), 80'(input_gain));
         thr = 80'(comp_threshold);
         c   = gl;
         if (comp_ratio != gcm_pkg::Q31_MAX) begin
            if (thr - c < 80'sd0) begin
               c = clamp_q31(thr + frac_mul(clamp_q31(c - thr), 80'(comp_ratio)));
            end else if (c + thr < 80'sd0) begin
               c = clamp_q31(frac_mul(clamp_q31(c + thr), 80'(comp_ratio)) - thr);
            end
         end
         ls  = frac_mul(gl, 80'(surround_gain[mix_mode]));
         lfe = frac_mul(c, 80'(lfe_gain[mix_mode]));
         mix = clamp_q31(clamp_q31(ls + gl) + lfe);
         rs  = frac_mul(gr, 80'(gcm_pkg::Q31_MIN));
         e.out_mix_left       = mix[31:0];
         e.out_gained_right   = gr[31:0];
         e.out_center         = f.in_center;
         e.out_left_surround  = ls[31:0];
         e.out_right_surround = rs[31:0];
         e.out_lfe            = lfe[31:0];
         e.out_aux_six        = f.in_aux_six;
         e.out_aux_seven      = f.in_aux_seven;
         return e;
      endfunction

      function void take_frame(input gcm_pkg::req_type f);
         pending_frames.push_back(predict_frame(f));
      endfunction

      task check_frame(input gcm_pkg::rsp_type got);
         gcm_pkg::rsp_type want;
         if (pending_frames.size() == 0) begin
            log_fault("result frame arrived with none outstanding");
            return;
         end
         want = pending_frames.pop_front();
         checked++;
         for (int k = 0; k < 8; k++) begin
            if (got[255-32*k -: 32] !== want[255-32*k -: 32]) begin
               log_fault($sformatf("frame %0d %s: got %h, want %h", checked, field_names[k],
                                   got[255-32*k -: 32], want[255-32*k -: 32]));
            end
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   gcm_pkg::req_type      req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   gcm_pkg::rsp_type      rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [INDEX_W-1:0]    csr_index;
   logic [DATA_W-1:0]     csr_data;

   mix_scoreboard sb;
   reg_write_type reg_writes [$];
   int            frames_in = 0;
   int            writes_done = 0;
   int            phases_run = 0;
   logic          steady;

   assign steady = frames_in >= 600 && frames_in < 780;

   gain_compressor_channel_mixer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.take_frame(req_payload);
            frames_in++;
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_frame(rsp_payload);
         end
         if (csr_valid && csr_ready) begin
            sb.set_register(csr_index, csr_data);
            writes_done++;
         end
      end
   end

   initial begin
      bit held_off;
      held_off  = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held_off && frames_in >= HOLD_OFF_AT) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 22);
         end
      end
   end

   initial begin
      #1_000_000;
      $display("gain_compressor_channel_mixer_core: mismatch");
      $finish;
   end

   function automatic gcm_pkg::req_type make_frame(input logic [31:0] l,
                                                   input logic [31:0] r,
                                                   input logic [31:0] c,
                                                   input logic [31:0] s6,
                                                   input logic [31:0] s7);
      gcm_pkg::req_type f;
      f.in_left      = l;
      f.in_right     = r;
      f.in_center    = c;
      f.in_aux_six   = s6;
      f.in_aux_seven = s7;
      return f;
   endfunction

   function automatic logic [31:0] random_sample();
      logic signed [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v = v >>> $urandom_range(1, 31);
         1: v = v[31] ? gcm_pkg::Q31_MIN + $urandom_range(0, 15)
                      : gcm_pkg::Q31_MAX - $urandom_range(0, 15);
         default: ;
      endcase
      return v;
   endfunction

   function automatic gcm_pkg::req_type random_frame();
      return make_frame(random_sample(), random_sample(), random_sample(),
                        random_sample(), random_sample());
   endfunction

   function automatic logic [39:0] random_reg();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[39:0];
   endfunction

   function automatic logic [39:0] random_gain();
      logic signed [39:0] g;
      g = random_reg();
      if ($urandom_range(0, 2) != 0) begin
         g = g >>> $urandom_range(6, 12);
      end
      return g;
   endfunction

   task automatic queue_write(input logic [INDEX_W-1:0] index,
                              input logic [DATA_W-1:0] data);
      reg_write_type w;
      w.index = index;
      w.data  = data;
      reg_writes.push_back(w);
   endtask

   task automatic randomise_all();
      for (int n = 0; n < 8; n++) begin
         queue_write(INDEX_W'(n), n >= 4 ? random_gain() : random_reg());
      end
   endtask

   task automatic send_frame(input gcm_pkg::req_type f);
      if (!steady && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
   endtask

   task automatic run_phase();
      reg_write_type w;
      while (reg_writes.size() != 0) begin
         w = reg_writes.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.index;
         csr_data  <= w.data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      send_frame(make_frame(gcm_pkg::Q31_MAX, gcm_pkg::Q31_MIN, gcm_pkg::Q31_MAX,
                            gcm_pkg::Q31_MIN, gcm_pkg::Q31_MAX));
      send_frame(make_frame(gcm_pkg::Q31_MIN, gcm_pkg::Q31_MAX, gcm_pkg::Q31_MIN,
                            gcm_pkg::Q31_MAX, gcm_pkg::Q31_MIN));
      send_frame(make_frame('0, '0, '0, '0, '0));
      send_frame(make_frame(-32'sd1, 32'sd1, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd1));
      for (int n = 0; n < PHASE_FRAMES; n++) begin
         send_frame(random_frame());
      end
      drain();
      phases_run++;
   endtask

   initial begin
      logic signed [31:0] knee;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      knee        = gcm_pkg::RST_COMP_THRESHOLD;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_frame(make_frame('0, '0, '0, '0, '0));
      send_frame(make_frame(gcm_pkg::Q31_MAX, gcm_pkg::Q31_MAX, gcm_pkg::Q31_MAX,
                            gcm_pkg::Q31_MAX, gcm_pkg::Q31_MAX));
      send_frame(make_frame(gcm_pkg::Q31_MIN, gcm_pkg::Q31_MIN, gcm_pkg::Q31_MIN,
                            gcm_pkg::Q31_MIN, gcm_pkg::Q31_MIN));
      send_frame(make_frame(-32'sd1, 32'sd1, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd0));
      send_frame(make_frame(32'sd1, -32'sd1, 32'hAAAA_AAAA, 32'h5555_5555, -32'sd1));
      send_frame(make_frame(2 * knee, gcm_pkg::Q31_MIN, 32'sd7, 32'sd8, 32'sd9));
      send_frame(make_frame(2 * knee + 2, gcm_pkg::Q31_MAX, '0, '0, '0));
      send_frame(make_frame(-2 * knee, '0, '0, '0, '0));
      send_frame(make_frame(-2 * knee - 2, 32'sd12345, '0, '0, '0));
      send_frame(make_frame(2 * knee - 2, -32'sd12345, '0, '0, '0));
      send_frame(make_frame(gcm_pkg::Q31_MAX, gcm_pkg::Q31_MIN, '0, '0, '0));
      send_frame(make_frame(gcm_pkg::Q31_MIN, gcm_pkg::Q31_MAX, '0, '0, '0));
      send_frame(make_frame(-32'sd2, gcm_pkg::Q31_MIN + 1, '0, '0, '0));
      send_frame(make_frame(gcm_pkg::Q31_MAX - 1, -32'sd2, '0, '0, '0));
      for (int n = 0; n < LEAD_FRAMES; n++) begin
         send_frame(random_frame());
      end
      drain();
      phases_run++;

      randomise_all();
      run_phase();

      queue_write(gcm_pkg::REG_INPUT_GAIN, DATA_W'(gcm_pkg::Q31_MAX));
      queue_write(gcm_pkg::REG_COMP_RATIO, DATA_W'(gcm_pkg::Q31_MAX));
      queue_write(gcm_pkg::REG_COMP_THRESHOLD, '0);
      queue_write(gcm_pkg::REG_MIX_MODE, DATA_W'(1));
      queue_write(gcm_pkg::REG_SURROUND_GAIN1, GAIN_MAX);
      queue_write(gcm_pkg::REG_LFE_GAIN1, GAIN_MIN);
      run_phase();

      queue_write(gcm_pkg::REG_INPUT_GAIN, DATA_W'(gcm_pkg::Q31_MIN));
      queue_write(gcm_pkg::REG_COMP_RATIO, DATA_W'(gcm_pkg::Q31_MIN));
      queue_write(gcm_pkg::REG_COMP_THRESHOLD, -40'sd536870912);
      queue_write(gcm_pkg::REG_MIX_MODE, DATA_W'(0));
      queue_write(gcm_pkg::REG_SURROUND_GAIN0, GAIN_MIN);
      queue_write(gcm_pkg::REG_LFE_GAIN0, GAIN_MAX);
      run_phase();

      queue_write(gcm_pkg::REG_INPUT_GAIN, random_reg());
      queue_write(gcm_pkg::REG_COMP_RATIO, '0);
      queue_write(gcm_pkg::REG_COMP_THRESHOLD, DATA_W'(gcm_pkg::Q31_MAX));
      queue_write(gcm_pkg::REG_MIX_MODE, DATA_W'(1));
      queue_write(gcm_pkg::REG_SURROUND_GAIN1, '0);
      queue_write(gcm_pkg::REG_LFE_GAIN1, '0);
      run_phase();

      queue_write(gcm_pkg::REG_INPUT_GAIN, DATA_W'(gcm_pkg::Q31_MAX));
      queue_write(gcm_pkg::REG_COMP_RATIO, DATA_W'(gcm_pkg::Q31_MAX - 32'sd1));
      queue_write(gcm_pkg::REG_COMP_THRESHOLD, DATA_W'(gcm_pkg::Q31_MIN));
      queue_write(gcm_pkg::REG_MIX_MODE, DATA_W'(0));
      queue_write(gcm_pkg::REG_SURROUND_GAIN0, random_gain());
      queue_write(gcm_pkg::REG_LFE_GAIN0, random_gain());
      run_phase();

      for (int n = 8; n < 16; n++) begin
         queue_write(INDEX_W'(n), random_reg());
      end
      queue_write(gcm_pkg::REG_MIX_MODE, DATA_W'(1));
      queue_write(gcm_pkg::REG_COMP_RATIO, random_reg());
      queue_write(gcm_pkg::REG_SURROUND_GAIN1, random_gain());
      queue_write(gcm_pkg::REG_LFE_GAIN1, random_gain());
      run_phase();

      randomise_all();
      run_phase();

      queue_write(gcm_pkg::REG_INPUT_GAIN, DATA_W'(gcm_pkg::RST_INPUT_GAIN));
      queue_write(gcm_pkg::REG_COMP_RATIO, DATA_W'(gcm_pkg::RST_COMP_RATIO));
      queue_write(gcm_pkg::REG_COMP_THRESHOLD, DATA_W'(gcm_pkg::RST_COMP_THRESHOLD));
      queue_write(gcm_pkg::REG_MIX_MODE, DATA_W'(gcm_pkg::RST_MIX_MODE));
      queue_write(gcm_pkg::REG_SURROUND_GAIN0, gcm_pkg::RST_SURROUND_GAIN0);
      queue_write(gcm_pkg::REG_SURROUND_GAIN1, gcm_pkg::RST_SURROUND_GAIN1);
      queue_write(gcm_pkg::REG_LFE_GAIN0, gcm_pkg::RST_LFE_GAIN0);
      queue_write(gcm_pkg::REG_LFE_GAIN1, gcm_pkg::RST_LFE_GAIN1);
      run_phase();

      repeat (2 * gcm_pkg::NUM_STAGES) @(negedge clock);
      if (sb.pending_frames.size() != 0) begin
         sb.log_fault($sformatf("%0d frames never returned", sb.pending_frames.size()));
      end
      $display("%0d frames in, %0d results compared across %0d register settings",
               frames_in, sb.checked, phases_run);
      $display("%0d register writes, %0d faults", writes_done, sb.failures);
      if (sb.failures == 0) begin
         $display("gain_compressor_channel_mixer_core: match");
      end else begin
         $display("gain_compressor_channel_mixer_core: mismatch");
      end
      $finish;
   end

endmodule
